/* hw/rtl/cbf_pkg.sv */
// Shared widths, types and defaults for the cubic Bezier flattener.
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  localparam int COORD_W   = 16;
  localparam int COEF_W    = 20;
  localparam int NUM_W     = 44;
  localparam int STEPS_DEF = 64;
  localparam int Q_DEPTH   = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NUM_W-1:0]   num_t;

  typedef struct packed {
    num_t num;
    num_t d1;
    num_t d2;
    num_t d3;
  } axis_init_t;

  typedef struct packed {
    axis_init_t x;
    axis_init_t y;
  } curve_init_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    num_t nx;
    num_t ny;
  } pt_num_t;

  typedef struct packed {
    logic   valid;
    logic   first;
    logic   last;
    coord_t x;
    coord_t y;
  } pt_res_t;

endpackage

`default_nettype wire

/* hw/rtl/cbf_front.sv */
// Front part: accept control points and build forward-difference start values.
`timescale 1ns / 1ps
`default_nettype none

module cbf_front #(
  parameter int STEPS = cbf_pkg::STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire cbf_pkg::coord_t      start_x,
  input  wire cbf_pkg::coord_t      start_y,
  input  wire cbf_pkg::coord_t      ctrl1_x,
  input  wire cbf_pkg::coord_t      ctrl1_y,
  input  wire cbf_pkg::coord_t      ctrl2_x,
  input  wire cbf_pkg::coord_t      ctrl2_y,
  input  wire cbf_pkg::coord_t      end_x,
  input  wire cbf_pkg::coord_t      end_y,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cbf_pkg::curve_init_t      q_data
);

  localparam int CW = cbf_pkg::COEF_W;
  localparam int NW = cbf_pkg::NUM_W;
  localparam logic signed [NW-1:0] S1 = NW'(STEPS);
  localparam logic signed [NW-1:0] S2 = NW'(STEPS * STEPS);
  localparam logic signed [NW-1:0] S3 = NW'(STEPS * STEPS * STEPS);

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    cbf_pkg::coord_t      p0;
  } coef_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    cbf_pkg::num_t        bs;
    cbf_pkg::num_t        cs2;
    cbf_pkg::num_t        p0s3;
  } prod_t;

  function automatic coef_t coeffs(input cbf_pkg::coord_t p0, input cbf_pkg::coord_t p1,
                                   input cbf_pkg::coord_t p2, input cbf_pkg::coord_t p3);
    logic signed [CW-1:0] e0, e1, e2, e3, d10, d21;
    coef_t r;
    e0  = CW'(p0);
    e1  = CW'(p1);
    e2  = CW'(p2);
    e3  = CW'(p3);
    d10 = e1 - e0;
    d21 = e2 - e1;
    r.c  = (d10 <<< 1) + d10;
    r.b  = (d21 <<< 1) + d21 - r.c;
    r.a  = e3 - e0 - r.c - r.b;
    r.p0 = p0;
    return r;
  endfunction

  function automatic prod_t prods(input coef_t cf);
    prod_t r;
    r.a    = cf.a;
    r.bs   = NW'(cf.b) * S1;
    r.cs2  = NW'(cf.c) * S2;
    r.p0s3 = NW'(cf.p0) * S3;
    return r;
  endfunction

  function automatic cbf_pkg::axis_init_t init(input prod_t pr);
    cbf_pkg::num_t a, a6;
    cbf_pkg::axis_init_t r;
    a     = NW'(pr.a);
    a6    = (a <<< 2) + (a <<< 1);
    r.num = pr.p0s3;
    r.d1  = a + pr.bs + pr.cs2;
    r.d2  = a6 + (pr.bs <<< 1);
    r.d3  = a6;
    return r;
  endfunction

  logic                 en;
  logic                 v1, v2, v3;
  coef_t                c1x, c1y;
  prod_t                p2x, p2y;
  cbf_pkg::curve_init_t init3;

  assign en     = !v3 || !q_full;
  assign full   = !en;
  assign q_push = v3 && !q_full;
  assign q_data = init3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1x     <= coeffs(start_x, ctrl1_x, ctrl2_x, end_x);
      c1y     <= coeffs(start_y, ctrl1_y, ctrl2_y, end_y);
      p2x     <= prods(c1x);
      p2y     <= prods(c1y);
      init3.x <= init(p2x);
      init3.y <= init(p2y);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cbf_queue.sv */
// Short queue of curve start values between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module cbf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire cbf_pkg::curve_init_t wr_data,
  output logic                      full,
  input  wire logic                 pop,
  output cbf_pkg::curve_init_t      rd_data,
  output logic                      empty
);

  localparam int DEPTH = cbf_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbf_pkg::curve_init_t mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(DEPTH))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> rd_ptr == wr_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cbf_stepper.sv */
// Back part: walk the curve numerator by forward differences, one step a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module cbf_stepper #(
  parameter int STEPS = cbf_pkg::STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 q_empty,
  input  wire cbf_pkg::curve_init_t q_data,
  output logic                      q_pop,
  output cbf_pkg::pt_num_t          pt
);

  localparam int K_W = $clog2(STEPS);

  function automatic cbf_pkg::axis_init_t step(input cbf_pkg::axis_init_t s);
    cbf_pkg::axis_init_t r;
    r.num = s.num + s.d1;
    r.d1  = s.d1 + s.d2;
    r.d2  = s.d2 + s.d3;
    r.d3  = s.d3;
    return r;
  endfunction

  logic                busy;
  logic [K_W-1:0]      k;
  logic                at_end;
  logic                free;
  cbf_pkg::axis_init_t cx, cy;

  assign at_end = k == K_W'(STEPS - 1);
  assign free   = !busy || at_end;
  assign q_pop  = en && free && !q_empty;

  assign pt.valid = busy;
  assign pt.first = k == '0;
  assign pt.last  = at_end;
  assign pt.nx    = cx.num;
  assign pt.ny    = cy.num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (en && free) begin
      busy <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx <= q_data.x;
      cy <= q_data.y;
      k  <= '0;
    end else if (en && busy) begin
      cx <= step(cx);
      cy <= step(cy);
      k  <= k + K_W'(1);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cbf_divider.sv */
// Back part: pipelined truncating division of both numerators by STEPS cubed.
`timescale 1ns / 1ps
`default_nettype none

module cbf_divider #(
  parameter int STEPS = cbf_pkg::STEPS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire cbf_pkg::pt_num_t din,
  output cbf_pkg::pt_res_t      dout
);

  localparam int QUO_W  = cbf_pkg::COORD_W;
  localparam int NW     = cbf_pkg::NUM_W;
  localparam int CUBE   = STEPS * STEPS * STEPS;
  localparam int CUBE_W = $clog2(CUBE);
  localparam int REM_W  = QUO_W + CUBE_W;
  localparam int SH     = CUBE_W - 1;
  localparam int HI_W   = REM_W - SH;
  localparam int PR_W   = 2 * HI_W;
  localparam int LAT    = 4;
  localparam logic [HI_W-1:0]  RCP  = HI_W'((64'd1 << REM_W) / 64'(CUBE));
  localparam logic [REM_W-1:0] DIV1 = REM_W'(CUBE);
  localparam logic [REM_W-1:0] DIV2 = REM_W'(2 * CUBE);

  // Estimate from the top bits; it is low by at most two.
  function automatic logic [HI_W-1:0] quo_est(input logic [REM_W-1:0] m);
    logic [PR_W-1:0] pr;
    pr = PR_W'(m[REM_W-1:SH]) * PR_W'(RCP);
    return pr[PR_W-1:HI_W];
  endfunction

  function automatic logic [REM_W-1:0] rem_of(input logic [REM_W-1:0] m,
                                               input logic [HI_W-1:0]  q);
    return m - REM_W'(q) * DIV1;
  endfunction

  function automatic logic [QUO_W-1:0] quo_fix(input logic [HI_W-1:0]  q,
                                               input logic [REM_W-1:0] r);
    logic [HI_W-1:0] qf;
    if (r >= DIV2) begin
      qf = q + HI_W'(2);
    end else if (r >= DIV1) begin
      qf = q + HI_W'(1);
    end else begin
      qf = q;
    end
    return qf[QUO_W-1:0];
  endfunction

  logic             v     [LAT];
  logic             first [LAT];
  logic             last  [LAT];
  logic             neg_x [LAT];
  logic             neg_y [LAT];
  logic [REM_W-1:0] mag_x [2];
  logic [REM_W-1:0] mag_y [2];
  logic [HI_W-1:0]  qe_x  [2];
  logic [HI_W-1:0]  qe_y  [2];
  logic [REM_W-1:0] rem_x, rem_y;
  logic [QUO_W-1:0] quo_x, quo_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= din.valid;
      for (int i = 1; i < LAT; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x[0] <= din.nx[NW-1];
      neg_y[0] <= din.ny[NW-1];
      first[0] <= din.first;
      last[0]  <= din.last;
      for (int i = 1; i < LAT; i++) begin
        neg_x[i] <= neg_x[i-1];
        neg_y[i] <= neg_y[i-1];
        first[i] <= first[i-1];
        last[i]  <= last[i-1];
      end
      mag_x[0] <= REM_W'(din.nx[NW-1] ? -din.nx : din.nx);
      mag_y[0] <= REM_W'(din.ny[NW-1] ? -din.ny : din.ny);
      mag_x[1] <= mag_x[0];
      mag_y[1] <= mag_y[0];
      qe_x[0]  <= quo_est(mag_x[0]);
      qe_y[0]  <= quo_est(mag_y[0]);
      qe_x[1]  <= qe_x[0];
      qe_y[1]  <= qe_y[0];
      rem_x    <= rem_of(mag_x[1], qe_x[0]);
      rem_y    <= rem_of(mag_y[1], qe_y[0]);
      quo_x    <= quo_fix(qe_x[1], rem_x);
      quo_y    <= quo_fix(qe_y[1], rem_y);
    end
  end

  assign dout.valid = v[LAT-1];
  assign dout.first = first[LAT-1];
  assign dout.last  = last[LAT-1];
  assign dout.x     = neg_x[LAT-1] ? -quo_x : quo_x;
  assign dout.y     = neg_y[LAT-1] ? -quo_y : quo_y;

endmodule

`default_nettype wire

/* hw/rtl/cubic_bezier_flattener.sv */
// Top level of the cubic Bezier flattener: front, queue, stepper, divider, output register.
//
//   channel   handshake        payload
//   input     push / full      start_x/y, ctrl1_x/y, ctrl2_x/y, end_x/y
//   result    pop / empty      seg_from_x/y, seg_to_x/y, last_segment
//
// Each curve gives STEPS segments, one per cycle from the stepper while the back part
// is not stalled, and the stepper takes the next curve while it emits the last segment.
// The first segment of a curve reaches the result ports through 3 front stages,
// the queue, the stepper, 4 divider stages and the output register.
// Reset empties every stage and the queue; a held result stalls the back part, and a
// full queue stalls the front part and raises full once its last stage holds a curve.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_flattener #(
  parameter int STEPS = cbf_pkg::STEPS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire cbf_pkg::coord_t start_x,
  input  wire cbf_pkg::coord_t start_y,
  input  wire cbf_pkg::coord_t ctrl1_x,
  input  wire cbf_pkg::coord_t ctrl1_y,
  input  wire cbf_pkg::coord_t ctrl2_x,
  input  wire cbf_pkg::coord_t ctrl2_y,
  input  wire cbf_pkg::coord_t end_x,
  input  wire cbf_pkg::coord_t end_y,
  output logic                 empty,
  input  wire logic            pop,
  output cbf_pkg::coord_t      seg_from_x,
  output cbf_pkg::coord_t      seg_from_y,
  output cbf_pkg::coord_t      seg_to_x,
  output cbf_pkg::coord_t      seg_to_y,
  output logic                 last_segment
);

  logic                 q_push, q_pop, q_full, q_empty;
  cbf_pkg::curve_init_t q_wr, q_rd;
  cbf_pkg::pt_num_t     pt;
  cbf_pkg::pt_res_t     res;
  logic                 en_b;
  logic                 out_valid;
  cbf_pkg::coord_t      prev_x, prev_y;

  assign en_b  = !out_valid || pop;
  assign empty = !out_valid;

  cbf_front #(.STEPS(STEPS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .start_x (start_x),
    .start_y (start_y),
    .ctrl1_x (ctrl1_x),
    .ctrl1_y (ctrl1_y),
    .ctrl2_x (ctrl2_x),
    .ctrl2_y (ctrl2_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr)
  );

  cbf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  cbf_stepper #(.STEPS(STEPS)) u_stepper (
    .clk     (clk),
    .rst     (rst),
    .en      (en_b),
    .q_empty (q_empty),
    .q_data  (q_rd),
    .q_pop   (q_pop),
    .pt      (pt)
  );

  cbf_divider #(.STEPS(STEPS)) u_divider (
    .clk  (clk),
    .rst  (rst),
    .en   (en_b),
    .din  (pt),
    .dout (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_b) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && res.valid) begin
      seg_to_x     <= res.x;
      seg_to_y     <= res.y;
      seg_from_x   <= res.first ? res.x : prev_x;
      seg_from_y   <= res.first ? res.y : prev_y;
      last_segment <= res.last;
      prev_x       <= res.x;
      prev_y       <= res.y;
    end
  end

`ifndef SYNTHESIS
  a_first_degenerate: assert property (@(posedge clk) disable iff (rst)
    en_b && res.valid && res.first |=> seg_from_x == seg_to_x && seg_from_y == seg_to_y)
    else $error("first segment of a curve is not degenerate");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("reset left items in flight");
  a_chain: assert property (@(posedge clk) disable iff (rst)
    en_b && res.valid && !res.first |=> seg_from_x == $past(prev_x))
    else $error("segment does not start at previous point");
`endif

endmodule

`default_nettype wire
